@@ src/smle_pkg.sv @@
package smle_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_LEAVE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Character codes
  localparam logic [7:0] KEY_EOL   = 8'd13;
  localparam logic [7:0] KEY_LF    = 8'd10;
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_BLANK = 8'd32;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // Wake sequence: m, o, n, then two line ends
  localparam logic [2:0] WAKE_LAST = 3'd4;

  localparam int INDEX_W     = 6;
  localparam int INDEX_COUNT = 2 ** INDEX_W;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_CHAR  = 3'd0,
    OP_BS    = 3'd1,
    OP_ESC   = 3'd2,
    OP_EOL   = 3'd3,
    OP_WAKE  = 3'd4,
    OP_READ  = 3'd5,
    OP_LEAVE = 3'd6
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [7:0]           ch;
    logic [INDEX_W-1:0]   index;
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_ONE       = 2'd0,
    SEQ_BS        = 2'd1,
    SEQ_PROMPT    = 2'd2,
    SEQ_CR_PROMPT = 2'd3
  } seq_e;

  // Prompt text: CR, "mon> "
  function automatic logic [7:0] prompt_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = KEY_EOL;
      3'd1:    b = CH_M;
      3'd2:    b = CH_O;
      3'd3:    b = CH_N;
      3'd4:    b = CH_GT;
      default: b = KEY_BLANK;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] seq_byte(input seq_e s, input logic [2:0] step,
                                          input logic [7:0] ch);
    logic [7:0] b;
    case (s)
      SEQ_ONE:       b = ch;
      SEQ_BS:        b = (step == 3'd1) ? KEY_BLANK : KEY_BS;
      SEQ_PROMPT:    b = prompt_byte(step);
      SEQ_CR_PROMPT: b = (step == 3'd0) ? KEY_EOL : prompt_byte(step - 3'd1);
      default:       b = ch;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] seq_end(input seq_e s);
    logic [2:0] e;
    case (s)
      SEQ_ONE:       e = 3'd0;
      SEQ_BS:        e = 3'd2;
      SEQ_PROMPT:    e = 3'd5;
      SEQ_CR_PROMPT: e = 3'd6;
      default:       e = 3'd0;
    endcase
    return e;
  endfunction

endpackage

@@ src/serial_monitor_line_editor_top.sv @@
// A transaction enters the command queue at acceptance; the sequencer pops it and the first
// result leaves through the registered output stage, then one transmit byte per cycle while not stalled.
// The sequencer handles one command at a time while the queue holds up to two more; a non-empty
// line end emits CR, then trims trailing blanks from the line store before reporting the length.
// Reset: asynchronous, active low; clears mode, wake match, line fill and queue.
// Line store contents are not cleared.
module serial_monitor_line_editor_top #(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  input  logic [5:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [6:0] line_length_o,
  output logic       last_o
);
  import smle_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  smle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  smle_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  smle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (q_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

endmodule

@@ src/smle_front.sv @@
module smle_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [5:0]            read_index_i,
  input  logic                  full_i,
  output logic                  push_o,
  output smle_pkg::cmd_t        cmd_o
);
  import smle_pkg::*;

  logic       monitor_q, monitor_d;
  logic [2:0] wake_q, wake_d;
  logic       accept;
  logic       eol;
  logic       hit;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign eol        = (rx_byte_i == KEY_EOL) || (rx_byte_i == KEY_LF);

  // Match the expected wake character
  always_comb begin
    unique case (wake_q)
      3'd0:    hit = (rx_byte_i == CH_M);
      3'd1:    hit = (rx_byte_i == CH_O);
      3'd2:    hit = (rx_byte_i == CH_N);
      3'd3:    hit = eol;
      3'd4:    hit = eol;
      default: hit = 1'b0;
    endcase
  end

  // Classify the transaction and update the mode
  always_comb begin
    monitor_d   = monitor_q;
    wake_d      = wake_q;
    push_o      = 1'b0;
    cmd_o.op    = OP_CHAR;
    cmd_o.ch    = rx_byte_i;
    cmd_o.index = read_index_i;
    if (accept) begin
      unique case (func_i)
        FUNC_RX: begin
          if (monitor_q) begin
            push_o = 1'b1;
            case (rx_byte_i)
              KEY_EOL: cmd_o.op = OP_EOL;
              KEY_BS:  cmd_o.op = OP_BS;
              KEY_ESC: cmd_o.op = OP_ESC;
              default: cmd_o.op = OP_CHAR;
            endcase
          end else if (!hit) begin
            wake_d = 3'd0;
          end else if (wake_q != WAKE_LAST) begin
            wake_d = wake_q + 3'd1;
          end else begin
            monitor_d = 1'b1;
            wake_d    = 3'd0;
            push_o    = 1'b1;
            cmd_o.op  = OP_WAKE;
          end
        end
        FUNC_READ: begin
          push_o   = 1'b1;
          cmd_o.op = OP_READ;
        end
        FUNC_LEAVE: begin
          monitor_d = 1'b0;
          wake_d    = 3'd0;
          push_o    = 1'b1;
          cmd_o.op  = OP_LEAVE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      monitor_q <= 1'b0;
      wake_q    <= 3'd0;
    end else begin
      monitor_q <= monitor_d;
      wake_q    <= wake_d;
    end
  end

endmodule

@@ src/smle_cmd_queue.sv @@
module smle_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smle_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output smle_pkg::cmd_t cmd_o
);
  import smle_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cmd_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/smle_back.sv @@
module smle_back #(
  parameter int LINE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  smle_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     out_kind_o,
  output logic [7:0]     out_byte_o,
  output logic [6:0]     line_length_o,
  output logic           last_o
);
  import smle_pkg::*;

  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int FILL_W = $clog2(LINE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EMIT     = 6'b000010,
    ST_TRIM_RD  = 6'b000100,
    ST_TRIM_CHK = 6'b001000,
    ST_REPORT   = 6'b010000,
    ST_READ     = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] fill_m1;
  seq_e              seq_q, seq_d;
  logic [2:0]        step_q, step_d;
  logic [7:0]        ch_q, ch_d;
  logic              trim_q, trim_d;

  logic [7:0]        mem_q [LINE_DEPTH];
  logic [7:0]        rd_data_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] wrap_tab [INDEX_COUNT];

  logic              out_valid_q;
  logic [1:0]        out_kind_q;
  logic [7:0]        out_byte_q;
  logic [6:0]        out_len_q;
  logic              out_last_q;
  logic              load_ok;
  logic              out_load;
  logic [1:0]        load_kind;
  logic [7:0]        load_byte;
  logic [6:0]        load_len;
  logic              load_last;

  // Build the read index wrap table at elaboration
  for (genvar gi = 0; gi < INDEX_COUNT; gi++) begin : g_wrap
    assign wrap_tab[gi] = ADDR_W'(gi % LINE_DEPTH);
  end

  assign fill_m1 = fill_q - FILL_W'(1);
  assign load_ok = !out_valid_q || !out_stall_i;

  // Sequence commands and drive the output stage
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    seq_d     = seq_q;
    step_d    = step_q;
    ch_d      = ch_q;
    trim_d    = trim_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = fill_q[ADDR_W-1:0];
    wdata     = cmd_i.ch;
    re        = 1'b0;
    raddr     = fill_m1[ADDR_W-1:0];
    out_load  = 1'b0;
    load_kind = KIND_TX;
    load_byte = seq_byte(seq_q, step_q, ch_q);
    load_len  = 7'd0;
    load_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          ch_d   = cmd_i.ch;
          step_d = 3'd0;
          trim_d = 1'b0;
          unique case (cmd_i.op)
            OP_CHAR: begin
              if (fill_q < FILL_W'(LINE_DEPTH)) begin
                we      = 1'b1;
                fill_d  = fill_q + FILL_W'(1);
                seq_d   = SEQ_ONE;
                state_d = ST_EMIT;
              end
            end
            OP_BS: begin
              if (fill_q != '0) begin
                fill_d  = fill_m1;
                seq_d   = SEQ_BS;
                state_d = ST_EMIT;
              end
            end
            OP_ESC: begin
              fill_d  = '0;
              seq_d   = SEQ_PROMPT;
              state_d = ST_EMIT;
            end
            OP_EOL: begin
              ch_d    = KEY_EOL;
              seq_d   = (fill_q == '0) ? SEQ_CR_PROMPT : SEQ_ONE;
              trim_d  = (fill_q != '0);
              state_d = ST_EMIT;
            end
            OP_WAKE: begin
              fill_d  = '0;
              we      = 1'b1;
              waddr   = '0;
              wdata   = 8'd0;
              seq_d   = SEQ_CR_PROMPT;
              state_d = ST_EMIT;
            end
            OP_READ: begin
              re      = 1'b1;
              raddr   = wrap_tab[cmd_i.index];
              state_d = ST_READ;
            end
            OP_LEAVE: begin
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_load  = 1'b1;
          load_last = (step_q == seq_end(seq_q)) && !trim_q;
          if (step_q == seq_end(seq_q)) begin
            state_d = trim_q ? ST_TRIM_RD : ST_IDLE;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      ST_TRIM_RD: begin
        if (fill_q == '0) begin
          state_d = ST_REPORT;
        end else begin
          re      = 1'b1;
          state_d = ST_TRIM_CHK;
        end
      end
      ST_TRIM_CHK: begin
        // Drop one trailing blank and look at the one before it
        if (rd_data_q == KEY_BLANK) begin
          fill_d  = fill_m1;
          state_d = ST_TRIM_RD;
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (load_ok) begin
          out_load  = 1'b1;
          load_kind = KIND_LINE;
          load_byte = 8'd0;
          load_len  = 7'(fill_q);
          load_last = 1'b1;
          fill_d    = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_READ: begin
        if (load_ok) begin
          out_load  = 1'b1;
          load_kind = KIND_READ;
          load_byte = rd_data_q;
          load_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Line store with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      trim_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      trim_q  <= trim_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold sequencer payload and output payload
  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    step_q <= step_d;
    ch_q   <= ch_d;
    if (out_load) begin
      out_kind_q <= load_kind;
      out_byte_q <= load_byte;
      out_len_q  <= load_len;
      out_last_q <= load_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign line_length_o = out_len_q;
  assign last_o        = out_last_q;

endmodule
